// ----- sv/mcspf_pkg.sv -----
// ----------------------------------------------------------------------------
// mcspf_pkg
// Shared types, widths and codes of the muon candidate scaled-pt filter.
// ----------------------------------------------------------------------------
package mcspf_pkg;

    localparam int PT_W    = 16;
    localparam int ETA_W   = 14;
    localparam int COEF_W  = 21;
    localparam int PACK_W  = 3 * COEF_W;
    localparam int CNT_W   = 8;
    localparam int DIFF_W  = COEF_W + 1;          // c - min_pt
    localparam int LP_W    = COEF_W + PT_W + 1;   // l * pt
    localparam int PSQ_W   = 2 * PT_W;            // pt * pt
    localparam int QP_W    = COEF_W + PSQ_W + 1;  // q * pt * pt
    localparam int SUM_W   = 56;                  // full-width scaled pt sum
    localparam int CIDX_W  = 3;

    localparam logic [CNT_W-1:0] MAX_COUNT = 8'd255;

    // |eta| region bounds, 0.9 and 1.2 in 1/1024 units
    localparam logic [ETA_W-1:0] CENTRAL_BOUND = 14'd922;
    localparam logic [ETA_W-1:0] OVERLAP_BOUND = 14'd1229;

    localparam logic [1:0] REGION_CENTRAL = 2'd0;
    localparam logic [1:0] REGION_OVERLAP = 2'd1;
    localparam logic [1:0] REGION_FORWARD = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_COEFF_CENTRAL = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_COEFF_OVERLAP = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_COEFF_FORWARD = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MIN_PT        = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_MIN_ETA       = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_MAX_ETA       = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_MIN_COUNT     = 3'd6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    typedef struct packed {
        logic        [PACK_W-1:0] coeff_central;
        logic        [PACK_W-1:0] coeff_overlap;
        logic        [PACK_W-1:0] coeff_forward;
        logic signed [COEF_W-1:0] min_pt;
        logic signed [ETA_W-1:0]  min_eta;
        logic signed [ETA_W-1:0]  max_eta;
        logic        [CNT_W-1:0]  min_count;
    } cfg_t;

    // classified candidate as it waits in the queue
    typedef struct packed {
        logic [PT_W-1:0] pt;
        logic [1:0]      region;
        logic            eta_ok;
        logic            last;
    } cand_t;

endpackage

// ----- sv/mcspf_front.sv -----
// ----------------------------------------------------------------------------
// mcspf_front
// Accept candidates, pick the eta region and apply the eta window cut.
// ----------------------------------------------------------------------------
module mcspf_front (
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [mcspf_pkg::PT_W-1:0]             s_pt,
    input  logic signed [mcspf_pkg::ETA_W-1:0]     s_eta,
    input  logic                                   s_last,
    input  mcspf_pkg::cfg_t                        cfg,
    input  logic                                   q_full,
    output logic                                   q_push,
    output mcspf_pkg::cand_t                       q_wdata
);

    logic [mcspf_pkg::ETA_W-1:0] abs_eta;

    // -8192 wraps to 8192, which still fits as unsigned
    assign abs_eta = s_eta[mcspf_pkg::ETA_W-1] ? mcspf_pkg::ETA_W'(-s_eta)
                                               : mcspf_pkg::ETA_W'(s_eta);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_wdata.pt     = s_pt;
        q_wdata.last   = s_last;
        q_wdata.eta_ok = (s_eta >= cfg.min_eta) && (s_eta <= cfg.max_eta);
        if (abs_eta < mcspf_pkg::CENTRAL_BOUND) begin
            q_wdata.region = mcspf_pkg::REGION_CENTRAL;
        end else if (abs_eta < mcspf_pkg::OVERLAP_BOUND) begin
            q_wdata.region = mcspf_pkg::REGION_OVERLAP;
        end else begin
            q_wdata.region = mcspf_pkg::REGION_FORWARD;
        end
    end

endmodule

// ----- sv/mcspf_queue.sv -----
// ----------------------------------------------------------------------------
// mcspf_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module mcspf_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mcspf_pkg::cand_t  wdata,
    output logic              full,
    input  logic              pop,
    output logic              rvalid,
    output mcspf_pkg::cand_t  rdata
);

    mcspf_pkg::cand_t                  mem [mcspf_pkg::QUEUE_DEPTH];
    logic [mcspf_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mcspf_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mcspf_pkg::QUEUE_CW-1:0]    count_reg, count_next;
    logic                              do_push, do_pop;

    assign full    = (count_reg == mcspf_pkg::QUEUE_CW'(mcspf_pkg::QUEUE_DEPTH));
    assign rvalid  = (count_reg != '0);
    assign rdata   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && rvalid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= mcspf_pkg::QUEUE_CW'(mcspf_pkg::QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == mcspf_pkg::QUEUE_CW'(mcspf_pkg::QUEUE_DEPTH))
            |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

endmodule

// ----- sv/mcspf_back.sv -----
// ----------------------------------------------------------------------------
// mcspf_back
// Evaluate the scaled pt polynomial, count passing candidates, drive results.
// ----------------------------------------------------------------------------
module mcspf_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mcspf_pkg::cfg_t                   cfg,
    input  logic                              q_valid,
    input  mcspf_pkg::cand_t                  q_rdata,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_passed,
    output logic [mcspf_pkg::CNT_W-1:0]       m_count_so_far,
    output logic                              m_event_end,
    output logic                              m_accept
);

    logic                                     adv;

    // stage 1: coefficient pick, l*pt and pt*pt
    logic [mcspf_pkg::PACK_W-1:0]             packed_sel;
    logic signed [mcspf_pkg::COEF_W-1:0]      c_sel, l_sel, q_sel;
    logic                                     v1_reg, v1_next;
    logic signed [mcspf_pkg::DIFF_W-1:0]      d1_reg, d1_next;
    logic signed [mcspf_pkg::LP_W-1:0]        lp1_reg, lp1_next;
    logic [mcspf_pkg::PSQ_W-1:0]              psq1_reg, psq1_next;
    logic signed [mcspf_pkg::COEF_W-1:0]      q1_reg, q1_next;
    logic                                     ok1_reg, ok1_next;
    logic                                     last1_reg, last1_next;

    // stage 2: q * pt * pt
    logic                                     v2_reg, v2_next;
    logic signed [mcspf_pkg::DIFF_W-1:0]      d2_reg, d2_next;
    logic signed [mcspf_pkg::LP_W-1:0]        lp2_reg, lp2_next;
    logic signed [mcspf_pkg::QP_W-1:0]        qp2_reg, qp2_next;
    logic                                     ok2_reg, ok2_next;
    logic                                     last2_reg, last2_next;

    // stage 3: sum, compare, count, result register
    logic signed [mcspf_pkg::SUM_W-1:0]       d_ext, lp_ext, qp_ext, sum;
    logic                                     pass;
    logic [mcspf_pkg::CNT_W-1:0]              shown;
    logic [mcspf_pkg::CNT_W-1:0]              pass_count_reg, pass_count_next;
    logic                                     m_valid_reg, m_valid_next;
    logic                                     m_passed_reg, m_passed_next;
    logic [mcspf_pkg::CNT_W-1:0]              m_count_reg, m_count_next;
    logic                                     m_end_reg, m_end_next;
    logic                                     m_accept_reg, m_accept_next;

    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && q_valid;

    always_comb begin
        case (q_rdata.region)
            mcspf_pkg::REGION_CENTRAL: packed_sel = cfg.coeff_central;
            mcspf_pkg::REGION_OVERLAP: packed_sel = cfg.coeff_overlap;
            default:                   packed_sel = cfg.coeff_forward;
        endcase
        c_sel = packed_sel[mcspf_pkg::COEF_W-1:0];
        l_sel = packed_sel[2*mcspf_pkg::COEF_W-1:mcspf_pkg::COEF_W];
        q_sel = packed_sel[3*mcspf_pkg::COEF_W-1:2*mcspf_pkg::COEF_W];
    end

    always_comb begin
        v1_next    = v1_reg;
        d1_next    = d1_reg;
        lp1_next   = lp1_reg;
        psq1_next  = psq1_reg;
        q1_next    = q1_reg;
        ok1_next   = ok1_reg;
        last1_next = last1_reg;
        if (adv) begin
            v1_next    = q_valid;
            // fold min_pt into c: the cut becomes a sign test
            d1_next    = {c_sel[mcspf_pkg::COEF_W-1], c_sel}
                       - {cfg.min_pt[mcspf_pkg::COEF_W-1], cfg.min_pt};
            lp1_next   = l_sel * $signed({1'b0, q_rdata.pt});
            psq1_next  = q_rdata.pt * q_rdata.pt;
            q1_next    = q_sel;
            ok1_next   = q_rdata.eta_ok;
            last1_next = q_rdata.last;
        end
    end

    always_comb begin
        v2_next    = v2_reg;
        d2_next    = d2_reg;
        lp2_next   = lp2_reg;
        qp2_next   = qp2_reg;
        ok2_next   = ok2_reg;
        last2_next = last2_reg;
        if (adv) begin
            v2_next    = v1_reg;
            d2_next    = d1_reg;
            lp2_next   = lp1_reg;
            qp2_next   = q1_reg * $signed({1'b0, psq1_reg});
            ok2_next   = ok1_reg;
            last2_next = last1_reg;
        end
    end

    always_comb begin
        d_ext  = {{(mcspf_pkg::SUM_W-mcspf_pkg::DIFF_W){d2_reg[mcspf_pkg::DIFF_W-1]}},
                  d2_reg};
        lp_ext = {{(mcspf_pkg::SUM_W-mcspf_pkg::LP_W){lp2_reg[mcspf_pkg::LP_W-1]}},
                  lp2_reg};
        qp_ext = {{(mcspf_pkg::SUM_W-mcspf_pkg::QP_W){qp2_reg[mcspf_pkg::QP_W-1]}},
                  qp2_reg};
        sum    = (d_ext <<< 20) + (lp_ext <<< 10) + qp_ext;
        pass   = !sum[mcspf_pkg::SUM_W-1] && ok2_reg;
        shown  = (pass && pass_count_reg < mcspf_pkg::MAX_COUNT)
               ? pass_count_reg + 1'b1 : pass_count_reg;

        pass_count_next = pass_count_reg;
        m_valid_next    = m_valid_reg;
        m_passed_next   = m_passed_reg;
        m_count_next    = m_count_reg;
        m_end_next      = m_end_reg;
        m_accept_next   = m_accept_reg;
        if (adv) begin
            m_valid_next = v2_reg;
            if (v2_reg) begin
                pass_count_next = last2_reg ? '0 : shown;
                m_passed_next   = pass;
                m_count_next    = shown;
                m_end_next      = last2_reg;
                m_accept_next   = last2_reg && (shown >= cfg.min_count);
            end
        end
    end

    always_ff @(posedge aclk) begin
        d1_reg       <= d1_next;
        lp1_reg      <= lp1_next;
        psq1_reg     <= psq1_next;
        q1_reg       <= q1_next;
        ok1_reg      <= ok1_next;
        last1_reg    <= last1_next;
        d2_reg       <= d2_next;
        lp2_reg      <= lp2_next;
        qp2_reg      <= qp2_next;
        ok2_reg      <= ok2_next;
        last2_reg    <= last2_next;
        m_passed_reg <= m_passed_next;
        m_count_reg  <= m_count_next;
        m_end_reg    <= m_end_next;
        m_accept_reg <= m_accept_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
            pass_count_reg <= '0;
        end else begin
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            m_valid_reg    <= m_valid_next;
            pass_count_reg <= pass_count_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_passed       = m_passed_reg;
    assign m_count_so_far = m_count_reg;
    assign m_event_end    = m_end_reg;
    assign m_accept       = m_accept_reg;

    a_clear_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && v2_reg && last2_reg |=> pass_count_reg == '0)
        else $error("pass count not cleared after event end");

    a_accept_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_accept_reg |-> m_end_reg)
        else $error("event accept outside event end");

    a_pass_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_passed_reg |-> m_count_reg != '0)
        else $error("passing candidate not counted");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !adv |=> v1_reg && $stable(lp1_reg))
        else $error("pipeline stage moved during stall");

endmodule

// ----- sv/muon_candidate_scaled_pt_filter.sv -----
// ----------------------------------------------------------------------------
// muon_candidate_scaled_pt_filter
// Cut muon candidates on region-scaled pt and eta, count them per event and
// flag the event when enough candidates pass.
// ----------------------------------------------------------------------------
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------------
//   s_       | s_valid / s_ready   | s_pt, s_eta, s_last
//   m_       | m_valid / m_ready   | m_passed, m_count_so_far, m_event_end, m_accept
//   cfg_     | cfg_we (no wait)    | cfg_index, cfg_data
//
// One word in and one word out per clock, sustained while m_ready stays high.
// From input accept to result valid, the queue entry is written at the accept
// edge, then the three back stages follow (multiply l*pt and pt*pt, multiply
// q*pt*pt, sum and count).
// Reset (aresetn, synchronous) loads the register defaults and clears the
// per-event count and all valid flags.
// A low m_ready with m_valid high freezes the back pipeline; the four-entry queue
// keeps taking words until full, then s_ready drops.
//
module muon_candidate_scaled_pt_filter (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [mcspf_pkg::PT_W-1:0]               s_pt,
    input  logic signed [mcspf_pkg::ETA_W-1:0]       s_eta,
    input  logic                                     s_last,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic                                     m_passed,
    output logic [mcspf_pkg::CNT_W-1:0]              m_count_so_far,
    output logic                                     m_event_end,
    output logic                                     m_accept,
    input  logic                                     cfg_we,
    input  logic [mcspf_pkg::CIDX_W-1:0]             cfg_index,
    input  logic [mcspf_pkg::PACK_W-1:0]             cfg_data
);

    mcspf_pkg::cfg_t   cfg_reg, cfg_next;
    mcspf_pkg::cand_t  q_wdata, q_rdata;
    logic              q_push, q_full, q_pop, q_valid;

    // Register bank: decode the write index, ignore unknown indexes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                mcspf_pkg::CFG_COEFF_CENTRAL: cfg_next.coeff_central = cfg_data;
                mcspf_pkg::CFG_COEFF_OVERLAP: cfg_next.coeff_overlap = cfg_data;
                mcspf_pkg::CFG_COEFF_FORWARD: cfg_next.coeff_forward = cfg_data;
                mcspf_pkg::CFG_MIN_PT:
                    cfg_next.min_pt = cfg_data[mcspf_pkg::COEF_W-1:0];
                mcspf_pkg::CFG_MIN_ETA:
                    cfg_next.min_eta = cfg_data[mcspf_pkg::ETA_W-1:0];
                mcspf_pkg::CFG_MAX_ETA:
                    cfg_next.max_eta = cfg_data[mcspf_pkg::ETA_W-1:0];
                mcspf_pkg::CFG_MIN_COUNT:
                    cfg_next.min_count = cfg_data[mcspf_pkg::CNT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // each coefficient set defaults to c = 1024, l = 0, q = 0
            cfg_reg.coeff_central <= 63'd1024;
            cfg_reg.coeff_overlap <= 63'd1024;
            cfg_reg.coeff_forward <= 63'd1024;
            cfg_reg.min_pt        <= -21'sd32;
            cfg_reg.min_eta       <= -14'sd5120;
            cfg_reg.max_eta       <= 14'sd5120;
            cfg_reg.min_count     <= 8'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify eta region and window, push into the queue.
    mcspf_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_pt    (s_pt),
        .s_eta   (s_eta),
        .s_last  (s_last),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    // Queue: decouple the front from back-pressure on the result side.
    mcspf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rvalid  (q_valid),
        .rdata   (q_rdata)
    );

    // Back: polynomial, pt cut, event count and result register.
    mcspf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_passed       (m_passed),
        .m_count_so_far (m_count_so_far),
        .m_event_end    (m_event_end),
        .m_accept       (m_accept)
    );

endmodule
